FILE: rtl/uart_rb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared constants, codes and beat/handshake types of the UART ring buffers.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    // ring storage and burst size
    localparam int TX_DEPTH   = 256;
    localparam int RX_DEPTH   = 512;
    localparam int FIFO_BURST = 16;

    localparam int TX_PTR_W   = $clog2(TX_DEPTH);
    localparam int RX_PTR_W   = $clog2(RX_DEPTH);
    localparam int TX_SIZE_W  = 9;
    localparam int RX_SIZE_W  = 10;
    localparam int BURST_W    = $clog2(FIFO_BURST + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [TX_SIZE_W-1:0] TX_SIZE_RESET = TX_SIZE_W'(TX_DEPTH);
    localparam logic [RX_SIZE_W-1:0] RX_SIZE_RESET = RX_SIZE_W'(RX_DEPTH);

    // action codes
    localparam logic [2:0] ACT_WRITE   = 3'd0;
    localparam logic [2:0] ACT_READ    = 3'd1;
    localparam logic [2:0] ACT_RECV    = 3'd2;
    localparam logic [2:0] ACT_BREAK   = 3'd3;
    localparam logic [2:0] ACT_TXEMPTY = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_HOST   = 2'd2;

    // event bits
    localparam logic [1:0] EV_NONE = 2'b00;
    localparam logic [1:0] EV_RX   = 2'b01;
    localparam logic [1:0] EV_TX   = 2'b10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_SIZE = 2'd1;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_in;
        logic       tx_idle;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_out;
        logic       accepted;
        logic       rx_nonempty;
        logic [1:0] event_bits;
        logic       tx_irq_on;
        logic       last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       tx_push;
        logic       tx_pop;
        logic       rx_push;
        logic       rx_pop;
        logic       irq_set;
        logic       irq_clr;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_acc;
        logic [1:0] emit_ev;
        logic       emit_last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] action;
        logic       tx_idle;
        logic       tx_full;
        logic       tx_empty;
        logic       rx_empty;
    } t_stat;

endpackage

FILE: rtl/uart_tx_rx_ring_buffers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers
// Transmit and receive byte rings between a host and a UART transmit FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: drive i_item and raise start; the item is taken at an edge
//   with start high and busy low. busy stays high until the item is done.
//   Result channel: each result beat is on o_result for exactly one cycle,
//   marked by o_result_strobe; the receiver cannot stall it. The final beat
//   of an item has last set.
//   Sequencing: an accepted single-result item passes the EXEC and RESP
//   states, then its beat leaves the result register; a new item is taken
//   only back in IDLE. A drain (host write with idle transmitter, or
//   transmitter-empty event) steps each byte through a ring memory read and
//   a beat issue, up to 16 bytes; the sequencer handles one item at a time.
//   Config channel: i_cfg_valid/o_cfg_ready with index and data; index 0 is
//   the transmit ring size, index 1 the receive ring size. Writing a size
//   empties that ring. Write only while the block is idle.
//   Reset: both rings empty, interrupt enable off, sizes 256 and 512.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  uart_rb_pkg::t_in                    i_item,
    output uart_rb_pkg::t_out                   o_result,
    output logic                                o_result_strobe,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [uart_rb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uart_rb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import uart_rb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    uart_rb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    uart_rb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

FILE: rtl/uart_rb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rb_ctrl
// Sequencer: decodes one item, steps ring updates, drains and result beats.
// ----------------------------------------------------------------------------
module uart_rb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  uart_rb_pkg::t_stat  i_stat,
    output uart_rb_pkg::t_cmd   o_cmd
);
    import uart_rb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_EXEC      = 5'b00010,
        S_RESP      = 5'b00100,
        S_DRAIN_RD  = 5'b01000,
        S_DRAIN_OUT = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_acc, n_acc;
    logic [1:0]         r_ev, n_ev;
    logic               r_rd_ok, n_rd_ok;
    logic [BURST_W-1:0] r_cnt, n_cnt;
    logic               drain_last;

    // last byte of a drain: burst used up or ring ran dry
    assign drain_last = (r_cnt == BURST_W'(FIFO_BURST)) || i_stat.tx_empty;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_ev    = r_ev;
        n_rd_ok = r_rd_ok;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_acc   = 1'b0;
                n_ev    = EV_NONE;
                n_rd_ok = 1'b0;
                n_cnt   = '0;
                n_state = S_RESP;
                unique case (i_stat.action)
                    ACT_WRITE: begin
                        if (!i_stat.tx_full) begin
                            o_cmd.tx_push = 1'b1;
                            n_acc         = 1'b1;
                            n_ev          = EV_TX;
                            if (i_stat.tx_idle) begin
                                o_cmd.irq_set = 1'b1;
                                n_state       = S_DRAIN_RD;
                            end
                        end
                    end
                    ACT_READ: begin
                        if (!i_stat.rx_empty) begin
                            o_cmd.rx_pop = 1'b1;
                            n_acc        = 1'b1;
                            n_rd_ok      = 1'b1;
                        end
                    end
                    ACT_RECV: begin
                        o_cmd.rx_push = 1'b1;
                        n_ev          = EV_RX;
                    end
                    ACT_BREAK: begin
                        n_ev = EV_RX;
                    end
                    ACT_TXEMPTY: begin
                        n_ev = EV_TX;
                        if (i_stat.tx_empty) begin
                            o_cmd.irq_clr = 1'b1;
                        end else begin
                            n_state = S_DRAIN_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_RESP: begin
                // ring state is already updated here
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = r_rd_ok ? KIND_HOST : KIND_STATUS;
                o_cmd.emit_acc  = r_acc;
                o_cmd.emit_ev   = {r_ev[1], r_ev[0] | (r_rd_ok & ~i_stat.rx_empty)};
                o_cmd.emit_last = 1'b1;
                n_state         = S_IDLE;
            end
            S_DRAIN_RD: begin
                o_cmd.tx_pop = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                n_state      = S_DRAIN_OUT;
            end
            S_DRAIN_OUT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = KIND_LINE;
                o_cmd.emit_acc  = r_acc;
                o_cmd.emit_ev   = r_ev;
                o_cmd.emit_last = drain_last;
                n_state         = drain_last ? S_IDLE : S_DRAIN_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= 1'b0;
            r_ev    <= EV_NONE;
            r_rd_ok <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_ev    <= n_ev;
            r_rd_ok <= n_rd_ok;
            r_cnt   <= n_cnt;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: rtl/uart_rb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rb_dp
// Ring storage, head/tail pointers, size registers and the result register.
// ----------------------------------------------------------------------------
module uart_rb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uart_rb_pkg::t_in                    i_item,
    input  logic                                i_cfg_we,
    input  logic [uart_rb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uart_rb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  uart_rb_pkg::t_cmd                   i_cmd,
    output uart_rb_pkg::t_stat                  o_stat,
    output uart_rb_pkg::t_out                   o_result,
    output logic                                o_result_strobe
);
    import uart_rb_pkg::*;

    logic [7:0]           tx_mem [TX_DEPTH];
    logic [7:0]           rx_mem [RX_DEPTH];

    t_in                  r_item;
    logic [TX_SIZE_W-1:0] r_tx_size;
    logic [RX_SIZE_W-1:0] r_rx_size;
    logic [TX_PTR_W-1:0]  r_tx_head, r_tx_tail;
    logic [RX_PTR_W-1:0]  r_rx_head, r_rx_tail;
    logic                 r_irq;
    logic [7:0]           r_tx_rd, r_rx_rd;
    t_out                 r_out;
    logic                 r_strobe;

    logic [TX_SIZE_W-1:0] tx_eff, tx_hinc, tx_tinc;
    logic [RX_SIZE_W-1:0] rx_eff, rx_hinc, rx_tinc;
    logic [TX_PTR_W-1:0]  tx_head_nx, tx_tail_nx;
    logic [RX_PTR_W-1:0]  rx_head_nx, rx_tail_nx;
    logic [7:0]           emit_data;

    // effective ring sizes, clamped to [2, depth]
    always_comb begin
        if (r_tx_size < TX_SIZE_W'(2))             tx_eff = TX_SIZE_W'(2);
        else if (r_tx_size > TX_SIZE_W'(TX_DEPTH)) tx_eff = TX_SIZE_W'(TX_DEPTH);
        else                                       tx_eff = r_tx_size;
        if (r_rx_size < RX_SIZE_W'(2))             rx_eff = RX_SIZE_W'(2);
        else if (r_rx_size > RX_SIZE_W'(RX_DEPTH)) rx_eff = RX_SIZE_W'(RX_DEPTH);
        else                                       rx_eff = r_rx_size;
    end

    // pointer increments with wrap at the effective size
    assign tx_hinc    = TX_SIZE_W'(r_tx_head) + 1'b1;
    assign tx_tinc    = TX_SIZE_W'(r_tx_tail) + 1'b1;
    assign rx_hinc    = RX_SIZE_W'(r_rx_head) + 1'b1;
    assign rx_tinc    = RX_SIZE_W'(r_rx_tail) + 1'b1;
    assign tx_head_nx = (tx_hinc >= tx_eff) ? '0 : tx_hinc[TX_PTR_W-1:0];
    assign tx_tail_nx = (tx_tinc >= tx_eff) ? '0 : tx_tinc[TX_PTR_W-1:0];
    assign rx_head_nx = (rx_hinc >= rx_eff) ? '0 : rx_hinc[RX_PTR_W-1:0];
    assign rx_tail_nx = (rx_tinc >= rx_eff) ? '0 : rx_tinc[RX_PTR_W-1:0];

    // status to controller
    assign o_stat.action   = r_item.action;
    assign o_stat.tx_idle  = r_item.tx_idle;
    assign o_stat.tx_full  = (tx_head_nx == r_tx_tail);
    assign o_stat.tx_empty = (r_tx_head == r_tx_tail);
    assign o_stat.rx_empty = (r_rx_head == r_rx_tail);

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // transmit ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.tx_push) begin
            tx_mem[r_tx_head] <= r_item.data_in;
        end
        if (i_cmd.tx_pop) begin
            r_tx_rd <= tx_mem[r_tx_tail];
        end
    end

    // receive ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_push) begin
            rx_mem[r_rx_head] <= r_item.data_in;
        end
        if (i_cmd.rx_pop) begin
            r_rx_rd <= rx_mem[r_rx_tail];
        end
    end

    // sizes, pointers and interrupt enable; a size write empties its ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_size <= TX_SIZE_RESET;
            r_rx_size <= RX_SIZE_RESET;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_irq     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_TX_SIZE) begin
                r_tx_size <= i_cfg_data[TX_SIZE_W-1:0];
                r_tx_head <= '0;
                r_tx_tail <= '0;
            end else begin
                if (i_cmd.tx_push) r_tx_head <= tx_head_nx;
                if (i_cmd.tx_pop)  r_tx_tail <= tx_tail_nx;
            end
            if (i_cfg_we && i_cfg_index == REG_RX_SIZE) begin
                r_rx_size <= i_cfg_data[RX_SIZE_W-1:0];
                r_rx_head <= '0;
                r_rx_tail <= '0;
            end else if (i_cmd.rx_push) begin
                r_rx_head <= rx_head_nx;
                // overwrite: drop the oldest byte
                if (rx_head_nx == r_rx_tail) r_rx_tail <= rx_tail_nx;
            end else if (i_cmd.rx_pop) begin
                r_rx_tail <= rx_tail_nx;
            end
            if (i_cmd.irq_set)      r_irq <= 1'b1;
            else if (i_cmd.irq_clr) r_irq <= 1'b0;
        end
    end

    // result data select
    always_comb begin
        case (i_cmd.emit_kind)
            KIND_LINE: emit_data = r_tx_rd;
            KIND_HOST: emit_data = r_rx_rd;
            default:   emit_data = 8'h00;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.kind        <= i_cmd.emit_kind;
            r_out.data_out    <= emit_data;
            r_out.accepted    <= i_cmd.emit_acc;
            r_out.rx_nonempty <= (r_rx_head != r_rx_tail);
            r_out.event_bits  <= i_cmd.emit_ev;
            r_out.tx_irq_on   <= r_irq;
            r_out.last        <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_result        = r_out;
    assign o_result_strobe = r_strobe;

endmodule
